[sv/ufr_pkg.sv]
// Shared types and constants for the UART idle-timeout frame receiver.
// Used by ufr_front, ufr_cmd_fifo, ufr_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

    localparam int CH_FIELD_W  = 3;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 7;
    localparam int TIME_W      = 32;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int ENABLE_W    = 8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // item kinds carried on tuser
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    localparam logic [CNT_W-1:0]  LIMIT_RESET     = 7'd64;
    localparam logic [TIME_W-1:0] THRESHOLD_RESET = 32'd10;

    // drain command passed from front to back
    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [CNT_W-1:0]      length;
    } t_cmd;

    // byte store request from front to the frame memory
    typedef struct packed {
        logic                  en;
        logic [CH_FIELD_W-1:0] channel;
        logic [CNT_W-1:0]      index;
        logic [BYTE_W-1:0]     data;
    } t_wr;

    // drain completion reported by the back end
    typedef struct packed {
        logic                  done;
        logic [CH_FIELD_W-1:0] channel;
    } t_done;

endpackage

`default_nettype wire

[sv/ufr_front.sv]
// Front end: accepts items and configuration writes, keeps per-channel counts,
// stores bytes and queues drain commands. Depends on ufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufr_front #(
    parameter int CHANNELS  = 2,
    parameter int BUF_DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_item_valid,
    output logic                                  o_item_ready,
    input  wire logic                             i_kind,
    input  wire logic [ufr_pkg::CH_FIELD_W-1:0]   i_channel,
    input  wire logic [ufr_pkg::BYTE_W-1:0]       i_rx_byte,
    input  wire logic [ufr_pkg::TIME_W-1:0]       i_now,
    input  wire logic                             i_cfg_valid,
    input  wire logic [ufr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ufr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                  o_cmd_valid,
    output ufr_pkg::t_cmd                         o_cmd,
    input  wire logic                             i_cmd_ready,
    output ufr_pkg::t_wr                          o_wr,
    input  wire ufr_pkg::t_done                   i_done
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [ufr_pkg::ENABLE_W-1:0] r_enabled;
    logic [ufr_pkg::CNT_W-1:0]    r_limit;
    logic [ufr_pkg::TIME_W-1:0]   r_threshold;
    logic [ufr_pkg::CNT_W-1:0]    r_byte_count [CHANNELS];
    logic [ufr_pkg::CNT_W-1:0]    r_seen_count [CHANNELS];
    logic [ufr_pkg::TIME_W-1:0]   r_change_time [CHANNELS];
    logic [CHANNELS-1:0]          r_pending;

    logic [CH_W-1:0]              ch_idx;
    logic                         ch_ok;
    logic                         ch_pending;
    logic                         accept;
    logic [ufr_pkg::CNT_W-1:0]    cnt;
    logic [ufr_pkg::CNT_W-1:0]    lim;
    logic [ufr_pkg::TIME_W-1:0]   elapsed;
    logic                         byte_take;
    logic                         poll_live;
    logic                         poll_mark;
    logic                         poll_fire;

    always_comb begin
        ch_idx     = i_channel[CH_W-1:0];
        ch_ok      = ({1'b0, i_channel} < 4'(CHANNELS)) && r_enabled[i_channel];
        ch_pending = ch_ok && r_pending[ch_idx];
        // hold bytes for a channel whose frame is queued or still being read out
        o_item_ready = i_cmd_ready && !(ch_pending && (i_kind == ufr_pkg::KIND_BYTE));
        accept     = i_item_valid && o_item_ready;
        cnt        = r_byte_count[ch_idx];
        lim        = (r_limit < ufr_pkg::CNT_W'(BUF_DEPTH)) ? r_limit
                                                            : ufr_pkg::CNT_W'(BUF_DEPTH);
        elapsed    = i_now - r_change_time[ch_idx];
        byte_take  = accept && ch_ok && (i_kind == ufr_pkg::KIND_BYTE) && (cnt < lim);
        poll_live  = accept && ch_ok && (i_kind == ufr_pkg::KIND_POLL) && (cnt != '0);
        poll_mark  = poll_live && (cnt != r_seen_count[ch_idx]);
        poll_fire  = poll_live && (cnt == r_seen_count[ch_idx]) && (elapsed > r_threshold);

        o_wr.en      = byte_take;
        o_wr.channel = i_channel;
        o_wr.index   = cnt;
        o_wr.data    = i_rx_byte;

        o_cmd_valid    = poll_fire;
        o_cmd.channel  = i_channel;
        o_cmd.length   = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= '0;
            r_limit     <= ufr_pkg::LIMIT_RESET;
            r_threshold <= ufr_pkg::THRESHOLD_RESET;
            r_pending   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_byte_count[c]  <= '0;
                r_seen_count[c]  <= '0;
                r_change_time[c] <= '0;
            end
        end else begin
            if (byte_take) begin
                r_byte_count[ch_idx] <= cnt + 1'b1;
            end
            if (poll_mark) begin
                r_seen_count[ch_idx]  <= cnt;
                r_change_time[ch_idx] <= i_now;
            end
            if (poll_fire) begin
                r_byte_count[ch_idx] <= '0;
                r_seen_count[ch_idx] <= '0;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_done.done && (i_done.channel == ufr_pkg::CH_FIELD_W'(c))) begin
                    r_pending[c] <= 1'b0;
                end
                if (poll_fire && (ch_idx == CH_W'(c))) begin
                    r_pending[c] <= 1'b1;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ufr_pkg::REG_ENABLED: begin
                        // a newly enabled channel starts empty
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (i_cfg_data[c] && !r_enabled[c]) begin
                                r_byte_count[c] <= '0;
                                r_seen_count[c] <= '0;
                            end
                        end
                        r_enabled <= i_cfg_data[ufr_pkg::ENABLE_W-1:0];
                    end
                    ufr_pkg::REG_LIMIT: begin
                        r_limit <= i_cfg_data[ufr_pkg::CNT_W-1:0];
                    end
                    ufr_pkg::REG_THRESHOLD: begin
                        r_threshold <= i_cfg_data[ufr_pkg::TIME_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[sv/ufr_cmd_fifo.sv]
// Two-entry queue of drain commands between front and back.
// Depends on ufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufr_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ufr_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output ufr_pkg::t_cmd       o_cmd
);

    ufr_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    logic          push_ok;
    logic          pop_ok;

    always_comb begin
        o_full  = (r_count == 2'd2);
        o_valid = (r_count != 2'd0);
        o_cmd   = r_slot[r_rd_ptr];
        push_ok = i_push && !o_full;
        pop_ok  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/ufr_back.sv]
// Back end: holds the frame memory and reads a queued frame out one byte per
// cycle into the output register while the output is not stalled. Depends on ufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufr_back #(
    parameter int CHANNELS  = 2,
    parameter int BUF_DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ufr_pkg::t_wr                    i_wr,
    input  wire logic                            i_cmd_valid,
    input  wire ufr_pkg::t_cmd                   i_cmd,
    output logic                                 o_cmd_pop,
    output ufr_pkg::t_done                       o_done,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ufr_pkg::CH_FIELD_W-1:0]       o_out_channel,
    output logic [ufr_pkg::BYTE_W-1:0]           o_frame_byte,
    output logic [ufr_pkg::CNT_W-1:0]            o_frame_length,
    output logic                                 o_last
);

    localparam int MEM_DEPTH = CHANNELS * BUF_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SUM_W     = 10;

    logic [ufr_pkg::BYTE_W-1:0]     r_mem [MEM_DEPTH];
    logic [ufr_pkg::BYTE_W-1:0]     r_rd_data;

    logic                           r_busy;
    logic [ufr_pkg::CH_FIELD_W-1:0] r_ch;
    logic [ufr_pkg::CNT_W-1:0]      r_len;
    logic [ufr_pkg::CNT_W-1:0]      r_idx;
    logic                           r_out_valid;
    logic [ufr_pkg::CH_FIELD_W-1:0] r_out_ch;
    logic [ufr_pkg::CNT_W-1:0]      r_out_len;
    logic                           r_out_last;

    logic [SUM_W-1:0]               wr_sum;
    logic [SUM_W-1:0]               rd_sum;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;
    logic                           advance;
    logic                           rd_en;
    logic                           is_last;

    always_comb begin
        wr_sum   = SUM_W'(i_wr.channel) * SUM_W'(BUF_DEPTH) + SUM_W'(i_wr.index);
        rd_sum   = SUM_W'(r_ch) * SUM_W'(BUF_DEPTH) + SUM_W'(r_idx);
        wr_addr  = wr_sum[ADDR_W-1:0];
        rd_addr  = rd_sum[ADDR_W-1:0];
        advance  = !r_out_valid || i_out_ready;
        rd_en    = r_busy && advance;
        is_last  = (r_idx + 1'b1) == r_len;
        o_cmd_pop      = !r_busy && i_cmd_valid;
        o_done.done    = rd_en && is_last;
        o_done.channel = r_ch;
        o_out_valid    = r_out_valid;
        o_out_channel  = r_out_ch;
        o_frame_byte   = r_rd_data;
        o_frame_length = r_out_len;
        o_last         = r_out_last;
    end

    // frame memory: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
                r_ch   <= i_cmd.channel;
                r_len  <= i_cmd.length;
                r_idx  <= '0;
            end
            if (rd_en) begin
                r_out_valid <= 1'b1;
                r_out_ch    <= r_ch;
                r_out_len   <= r_len;
                r_out_last  <= is_last;
                r_idx       <= r_idx + 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[sv/uart_idle_timeout_frame_receiver.sv]
// Usage notes
// Input stream (s_axis_*): one transaction per item. tuser carries the kind
// (received byte or idle poll); tdata carries channel, byte and tick.
// Configuration channel (i_cfg_*): one register write per transaction, index 0
// enabled channels, 1 frame limit, 2 idle threshold; always ready. Write only
// while the block is idle.
// Output stream (m_axis_*): one transaction per frame byte, tlast on the last.
// Throughput: one input item per cycle unless stalled as below. A delivering
// poll is classified and queued at its accepting edge; the read-out engine
// takes the command once it is free and fetches the first byte into the output
// register; the rest follow one per cycle while the output is not stalled, set
// by the single read port of the frame memory. A frame of N bytes leaves as N
// output transactions, at most 64. Up to two delivering polls queue behind a
// frame being read out; while the queue is full every input item stalls. A
// received byte for a channel whose frame is queued or being read out waits
// until its last byte has been fetched.
// Reset clears counts, queue and output; the frame memory holds no reset
// value and needs no clearing pass.
// When the receiver drops tready the output transaction holds and the read-out
// pauses; the front keeps taking items until the command queue fills.
`timescale 1ns / 1ps
`default_nettype none

module uart_idle_timeout_frame_receiver #(
    parameter int CHANNELS  = 2,
    parameter int BUF_DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream: item in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: channel[2:0], rx_byte[10:3], now[42:11], zero[47:43]
    input  wire logic [ufr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: kind[0]
    input  wire logic                               s_axis_tuser,
    // master stream: frame bytes out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: out_channel[2:0], frame_byte[10:3], frame_length[17:11], zero[23:18]
    output logic [ufr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tlast,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ufr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ufr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                               cmd_push;
    ufr_pkg::t_cmd                      cmd_in;
    logic                               cmd_full;
    logic                               cmd_pop;
    logic                               cmd_valid;
    ufr_pkg::t_cmd                      cmd_head;
    ufr_pkg::t_wr                       wr_req;
    ufr_pkg::t_done                     drain_done;
    logic [ufr_pkg::CH_FIELD_W-1:0]     out_channel;
    logic [ufr_pkg::BYTE_W-1:0]         frame_byte;
    logic [ufr_pkg::CNT_W-1:0]          frame_length;

    assign o_cfg_ready = 1'b1;

    // classify items, update per-channel counts, store bytes
    ufr_front #(
        .CHANNELS  (CHANNELS),
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_channel    (s_axis_tdata[2:0]),
        .i_rx_byte    (s_axis_tdata[10:3]),
        .i_now        (s_axis_tdata[42:11]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cmd_valid  (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_ready  (!cmd_full),
        .o_wr         (wr_req),
        .i_done       (drain_done)
    );

    // decouple classification from read-out
    ufr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    // frame memory and read-out
    ufr_back #(
        .CHANNELS  (CHANNELS),
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr_req),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd_head),
        .o_cmd_pop      (cmd_pop),
        .o_done         (drain_done),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_channel  (out_channel),
        .o_frame_byte   (frame_byte),
        .o_frame_length (frame_length),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, frame_length, frame_byte, out_channel};

endmodule

`default_nettype wire

[sv/ufr_checker.sv]
// Port-level checks for the UART idle-timeout frame receiver, bound to the top.
// Depends on ufr_pkg and uart_idle_timeout_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

module ufr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ufr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tlast
);

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // a delivered frame is never empty
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:11] != 7'd0))
        else $error("zero frame length");

    // bytes of one frame share channel and length
    a_frame_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid ||
            ((m_axis_tdata[2:0] == $past(m_axis_tdata[2:0])) &&
             (m_axis_tdata[17:11] == $past(m_axis_tdata[17:11]))))
        else $error("frame header changed mid-frame");

    // a single-byte frame carries tlast on its only byte
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[17:11] == 7'd1) |-> m_axis_tlast)
        else $error("one-byte frame without tlast");

endmodule

bind uart_idle_timeout_frame_receiver ufr_checker u_ufr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[dv/uart_idle_timeout_frame_receiver_test.sv]
// Self-checking testbench for uart_idle_timeout_frame_receiver: streams bytes and idle polls
// in, predicts each delivered frame byte and checks the output stream in order.
// Depends on ufr_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module uart_idle_timeout_frame_receiver_test;

    localparam int CHANNELS    = 2;
    localparam int BUF_DEPTH   = 64;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYC  = 10;

    // index 3 decodes to no register; writing it must change nothing
    localparam logic [ufr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} t_rx_mode;

    // one expected transaction on the output stream
    typedef struct packed {
        logic [ufr_pkg::CH_FIELD_W-1:0] chan;
        logic [ufr_pkg::BYTE_W-1:0]     data;
        logic [ufr_pkg::CNT_W-1:0]      len;
        logic                           last;
    } t_frame_byte;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [ufr_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [ufr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [ufr_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [ufr_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    // frame bytes still owed by the block, oldest first
    t_frame_byte frame_bytes_due[$];

    // shadow of the block: stored frames, counts and registers
    logic [ufr_pkg::BYTE_W-1:0]   store_mem [CHANNELS][BUF_DEPTH];
    int unsigned                  held_cnt   [CHANNELS];
    int unsigned                  polled_cnt [CHANNELS];
    logic [ufr_pkg::TIME_W-1:0]   mark_tick  [CHANNELS];
    logic [ufr_pkg::ENABLE_W-1:0] en_mask;
    logic [ufr_pkg::CNT_W-1:0]    limit_reg;
    logic [ufr_pkg::TIME_W-1:0]   idle_reg;

    int       mismatch_cnt;
    int       burst_left;
    int       gap_max;
    int       hold_left;
    t_rx_mode rx_mode;
    logic [7:0] rx_pattern;

    uart_idle_timeout_frame_receiver #(
        .CHANNELS  (CHANNELS),
        .BUF_DEPTH (BUF_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run of this stimulus.
    initial begin
        #(64'd20_000_000);
        $display("** uart_idle_timeout_frame_receiver: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame prediction: apply one accepted item to the shadow state and
    // queue every frame byte it releases.
    // ------------------------------------------------------------------
    function automatic void update_frames(input logic kind,
                                          input logic [ufr_pkg::CH_FIELD_W-1:0] chan,
                                          input logic [ufr_pkg::BYTE_W-1:0] data,
                                          input logic [ufr_pkg::TIME_W-1:0] tick);
        int unsigned                cnt;
        int unsigned                lim;
        logic [ufr_pkg::TIME_W-1:0] elapsed;
        t_frame_byte                fb;
        // ignore channels beyond the instance or without a registered receiver
        if (chan >= CHANNELS || !en_mask[chan])
            return;
        cnt = held_cnt[chan];
        if (kind == ufr_pkg::KIND_BYTE) begin
            lim = (limit_reg < BUF_DEPTH) ? limit_reg : BUF_DEPTH;
            // drop silently once the frame is full
            if (cnt < lim) begin
                store_mem[chan][cnt] = data;
                held_cnt[chan] = cnt + 1;
            end
            return;
        end
        if (cnt == 0)
            return;
        // new bytes since the last poll: restart the idle clock
        if (cnt != polled_cnt[chan]) begin
            polled_cnt[chan] = cnt;
            mark_tick[chan] = tick;
            return;
        end
        // elapsed time wraps modulo 2^32
        elapsed = tick - mark_tick[chan];
        if (elapsed <= idle_reg)
            return;
        for (int i = 0; i < cnt; i++) begin
            fb.chan = chan;
            fb.data = store_mem[chan][i];
            fb.len  = ufr_pkg::CNT_W'(cnt);
            fb.last = (i == cnt - 1);
            frame_bytes_due.push_back(fb);
        end
        held_cnt[chan] = 0;
        polled_cnt[chan] = 0;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Output checker: every accepted transaction against the oldest
    // expected frame byte.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_output
        t_frame_byte want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            // tdata: out_channel[2:0], frame_byte[10:3], frame_length[17:11]
            if (frame_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte: ch %0d data %02h len %0d last %b",
                                          m_axis_tdata[2:0], m_axis_tdata[10:3],
                                          m_axis_tdata[17:11], m_axis_tlast));
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_axis_tdata[2:0] !== want.chan || m_axis_tdata[10:3] !== want.data ||
                    m_axis_tdata[17:11] !== want.len || m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf(
                        "got ch %0d data %02h len %0d last %b, want ch %0d data %02h len %0d last %b",
                        m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[17:11], m_axis_tlast,
                        want.chan, want.data, want.len, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: stall on the chosen pattern, or hold off completely
    // while a long hold is counting down.
    // ------------------------------------------------------------------
    initial begin : drive_output_ready
        int phase;
        phase = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_STEADY:  m_axis_tready = 1'b1;
                    RX_RANDOM:  m_axis_tready = ($urandom_range(0, 99) >= 35);
                    default: begin
                        m_axis_tready = rx_pattern[phase];
                        phase = (phase + 1) % 8;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item; bursts of random length with random gaps in between.
    task automatic send_item(input logic kind, input logic [ufr_pkg::CH_FIELD_W-1:0] chan,
                             input logic [ufr_pkg::BYTE_W-1:0] data,
                             input logic [ufr_pkg::TIME_W-1:0] tick);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        // tdata: channel[2:0], rx_byte[10:3], now[42:11], zero[47:43]
        s_axis_tdata  = {5'd0, tick, data, chan};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        update_frames(kind, chan, data, tick);
    endtask

    task automatic send_bytes(input logic [ufr_pkg::CH_FIELD_W-1:0] chan, input int n);
        repeat (n) send_item(ufr_pkg::KIND_BYTE, chan, ufr_pkg::BYTE_W'($urandom), $urandom);
    endtask

    task automatic poll(input logic [ufr_pkg::CH_FIELD_W-1:0] chan,
                        input logic [ufr_pkg::TIME_W-1:0] tick);
        send_item(ufr_pkg::KIND_POLL, chan, ufr_pkg::BYTE_W'($urandom), tick);
    endtask

    // Drop tvalid, wait for every owed byte, then let in-flight items settle.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (frame_bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (frame_bytes_due.size() != 0) begin
            report_mismatch($sformatf("%0d frame bytes never delivered", frame_bytes_due.size()));
            frame_bytes_due.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // One register write; only called with the block idle.
    task automatic write_reg(input logic [ufr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ufr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            ufr_pkg::REG_ENABLED: begin
                // a newly registered receiver starts from an empty frame
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (val[ch] && !en_mask[ch]) begin
                        held_cnt[ch] = 0;
                        polled_cnt[ch] = 0;
                    end
                end
                en_mask = val[ufr_pkg::ENABLE_W-1:0];
            end
            ufr_pkg::REG_LIMIT:     limit_reg = val[ufr_pkg::CNT_W-1:0];
            ufr_pkg::REG_THRESHOLD: idle_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing is registered after reset: bytes and polls fall on the floor.
    task automatic test_disabled_after_reset();
        send_item(ufr_pkg::KIND_BYTE, 3'd0, 8'h5a, 32'd0);
        poll(3'd0, 32'd100);
        poll(3'd0, 32'd200);
        wait_for_drain();
        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_00ff);
    endtask

    // Default threshold: the boundary tick, tick wrap, restart on new bytes,
    // out-of-range channel and empty poll.
    task automatic test_idle_delivery();
        send_item(ufr_pkg::KIND_BYTE, 3'd0, 8'h00, 32'hffff_ffff);
        send_item(ufr_pkg::KIND_BYTE, 3'd0, 8'hff, 32'h0000_0000);
        poll(3'd0, 32'd100);
        poll(3'd0, 32'd110);
        poll(3'd0, 32'd111);
        send_item(ufr_pkg::KIND_BYTE, 3'd7, 8'ha5, 32'd0);
        poll(3'd7, 32'd0);
        poll(3'd1, 32'd5);
        send_item(ufr_pkg::KIND_BYTE, 3'd1, 8'h3c, 32'd0);
        poll(3'd1, 32'hffff_fffa);
        poll(3'd1, 32'd5);
        send_item(ufr_pkg::KIND_BYTE, 3'd0, 8'h81, 32'd0);
        poll(3'd0, 32'd200);
        send_item(ufr_pkg::KIND_BYTE, 3'd0, 8'h7e, 32'd0);
        poll(3'd0, 32'd300);
        poll(3'd0, 32'd311);
        wait_for_drain();
    endtask

    // Full frame, zero limit, and a limit lowered below the stored count.
    task automatic test_frame_limit();
        write_reg(ufr_pkg::REG_LIMIT, 32'd1);
        send_bytes(3'd0, 2);
        poll(3'd0, 32'd0);
        poll(3'd0, 32'd20);
        wait_for_drain();
        write_reg(ufr_pkg::REG_LIMIT, 32'd0);
        send_bytes(3'd1, 1);
        poll(3'd1, 32'd0);
        wait_for_drain();
        write_reg(ufr_pkg::REG_LIMIT, 32'd64);
        send_bytes(3'd0, 3);
        wait_for_drain();
        write_reg(ufr_pkg::REG_LIMIT, 32'd2);
        send_bytes(3'd0, 1);
        poll(3'd0, 32'd0);
        poll(3'd0, 32'd50);
        wait_for_drain();
    endtask

    // Rewriting a set bit keeps the frame; a fresh registration clears it.
    task automatic test_enable_toggle();
        write_reg(ufr_pkg::REG_LIMIT, 32'd64);
        send_bytes(3'd1, 2);
        send_bytes(3'd0, 2);
        wait_for_drain();
        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_00ff);
        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_00fd);
        send_bytes(3'd1, 1);
        poll(3'd1, 32'd0);
        poll(3'd0, 32'd0);
        poll(3'd0, 32'd40);
        wait_for_drain();
        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_00ff);
        poll(3'd1, 32'd0);
        poll(3'd1, 32'd90);
        wait_for_drain();
    endtask

    // Threshold at both ends of its range, plus a write to the unused index.
    task automatic test_threshold_extremes();
        write_reg(ufr_pkg::REG_THRESHOLD, 32'd0);
        write_reg(REG_SPARE, 32'hffff_ffff);
        send_bytes(3'd0, 1);
        poll(3'd0, 32'd7);
        poll(3'd0, 32'd7);
        poll(3'd0, 32'd8);
        wait_for_drain();
        write_reg(ufr_pkg::REG_THRESHOLD, 32'hffff_ffff);
        send_bytes(3'd1, 1);
        poll(3'd1, 32'd0);
        poll(3'd1, 32'hffff_ffff);
        wait_for_drain();
        write_reg(ufr_pkg::REG_THRESHOLD, 32'hffff_fffe);
        poll(3'd1, 32'hffff_ffff);
        wait_for_drain();
    endtask

    // Hold the output off for a long stretch while frames keep being
    // released, so the read-out backs up and the input stalls.
    task automatic test_backpressure();
        write_reg(ufr_pkg::REG_THRESHOLD, 32'd0);
        gap_max = 0;
        rx_mode = RX_STEADY;
        hold_left = 300;
        for (int r = 0; r < 2; r++) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                send_bytes(ufr_pkg::CH_FIELD_W'(ch), 8);
                poll(ufr_pkg::CH_FIELD_W'(ch), 32'd10);
                poll(ufr_pkg::CH_FIELD_W'(ch), 32'd11);
            end
        end
        wait_for_drain();
        gap_max = 4;
        rx_mode = RX_RANDOM;
    endtask

    // Mostly complete frames with random content; the rest is noise and
    // frames left half-polled or interleaved.
    task automatic random_phase(input int count);
        int                             sent;
        int                             pick;
        int                             n;
        logic [ufr_pkg::CH_FIELD_W-1:0] ch;
        logic [ufr_pkg::TIME_W-1:0]     tick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            ch = ufr_pkg::CH_FIELD_W'($urandom_range(0, CHANNELS - 1));
            tick = $urandom;
            if (pick < 70) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
                send_bytes(ch, n);
                poll(ch, tick);
                sent += n + 2;
                if ($urandom_range(0, 9) == 0) begin
                    send_bytes(ch, 1);
                    poll(ch, tick);
                    sent += 2;
                end
                case ($urandom_range(0, 3))
                    0:       poll(ch, tick + idle_reg);
                    1:       poll(ch, $urandom);
                    default: poll(ch, tick + idle_reg + 1 + $urandom_range(0, 5));
                endcase
            end else if (pick < 85) begin
                send_item(1'($urandom_range(0, 1)),
                          ufr_pkg::CH_FIELD_W'($urandom_range(0, 7)),
                          ufr_pkg::BYTE_W'($urandom), $urandom);
                sent += 1;
            end else begin
                send_bytes(ch, $urandom_range(1, 3));
                poll(ch, tick);
                send_bytes(ch ^ 3'd1, 1);
                poll(ch ^ 3'd1, tick + 1);
                sent += 5;
            end
        end
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        logic [7:0]                 mask;
        logic [ufr_pkg::TIME_W-1:0] tick;
        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_0003);
        write_reg(ufr_pkg::REG_LIMIT, 32'd64);
        write_reg(ufr_pkg::REG_THRESHOLD, $urandom_range(0, 20));
        random_phase(12);

        // one channel dropped, short frames, zero threshold, patterned stalls
        mask = 8'($urandom_range(0, 255));
        mask[1:0] = 2'b01;
        write_reg(ufr_pkg::REG_ENABLED, ufr_pkg::CFG_DATA_W'(mask));
        write_reg(ufr_pkg::REG_LIMIT, $urandom_range(1, 10));
        write_reg(ufr_pkg::REG_THRESHOLD, 32'd0);
        rx_mode = RX_PATTERN;
        rx_pattern = 8'($urandom_range(1, 255));
        random_phase(12);

        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_00ff);
        write_reg(ufr_pkg::REG_LIMIT, $urandom_range(1, 64));
        write_reg(ufr_pkg::REG_THRESHOLD, $urandom_range(0, 1000));
        rx_mode = RX_RANDOM;
        gap_max = 0;
        random_phase(12);

        // limit above the buffer depth: the longest frame the block can hold
        write_reg(ufr_pkg::REG_ENABLED, 32'h0000_0003);
        write_reg(ufr_pkg::REG_LIMIT, 32'd127);
        write_reg(ufr_pkg::REG_THRESHOLD, 32'h8000_0000);
        gap_max = 4;
        tick = $urandom;
        send_bytes(3'd0, 66);
        poll(3'd0, tick);
        poll(3'd0, tick + 32'h8000_0001);
        rx_mode = RX_PATTERN;
        rx_pattern = 8'($urandom_range(1, 255));
        random_phase(12);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ufr_pkg::KIND_BYTE;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = ufr_pkg::REG_ENABLED;
        i_cfg_data    = '0;
        mismatch_cnt  = 0;
        burst_left    = 0;
        gap_max       = 4;
        hold_left     = 0;
        rx_mode       = RX_RANDOM;
        rx_pattern    = 8'hff;
        en_mask       = '0;
        limit_reg     = ufr_pkg::LIMIT_RESET;
        idle_reg      = ufr_pkg::THRESHOLD_RESET;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            held_cnt[ch]   = 0;
            polled_cnt[ch] = 0;
            mark_tick[ch]  = '0;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled_after_reset();
        test_idle_delivery();
        test_frame_limit();
        test_enable_toggle();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic();

        wait_for_drain();
        if (mismatch_cnt == 0) begin
            $display("** uart_idle_timeout_frame_receiver: PASSED **");
        end else begin
            $display("** uart_idle_timeout_frame_receiver: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ufr_pkg.sv
sv/ufr_front.sv
sv/ufr_cmd_fifo.sv
sv/ufr_back.sv
sv/uart_idle_timeout_frame_receiver.sv
sv/ufr_checker.sv
dv/uart_idle_timeout_frame_receiver_test.sv
